// ----- rtl/lcs_pkg.sv -----
// ----------------------------------------------------------------------------
// lcs_pkg - shared types and constants for the LCS engine
// Sizes, payload structs, opcodes, sequencer states and table addressing.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int MAX_LEN = 32;
  localparam int ROW     = MAX_LEN + 1;
  localparam int CW      = $clog2(MAX_LEN + 1);          // counts 0..MAX_LEN
  localparam int IW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int TAW     = $clog2(ROW * ROW);            // score table address
  localparam int SW      = 6;                            // score width
  localparam int POS_W   = 5;

  localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
  localparam logic [1:0] OP_RUN           = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] symbol;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             in_first;
    logic             in_second;
    logic [5:0]       lcs_length;
    logic             overflow;
    logic             last;
  } out_t;

  // result of the shared cell unit
  typedef struct packed {
    logic          match;   // symbols equal
    logic          ge;      // up >= left
    logic [SW-1:0] score;   // new cell value
  } cell_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_TB_RD,
    ST_TB_DEC,
    ST_EMIT
  } state_t;

  function automatic logic [TAW-1:0] tbl_addr(input logic [CW-1:0] i,
                                              input logic [CW-1:0] j);
    return TAW'(int'(i) * ROW + int'(j));
  endfunction

endpackage

// ----- rtl/lcs_cell_unit.sv -----
// ----------------------------------------------------------------------------
// lcs_cell_unit - shared compare / max unit
// Symbol compare, score compare and cell update, used by fill and traceback.
// ----------------------------------------------------------------------------
module lcs_cell_unit (
  input  logic [7:0]              sym_a,
  input  logic [7:0]              sym_b,
  input  logic [lcs_pkg::SW-1:0]  up,
  input  logic [lcs_pkg::SW-1:0]  up_left,
  input  logic [lcs_pkg::SW-1:0]  left,
  output lcs_pkg::cell_res_t      res
);

  always_comb begin
    res.match = (sym_a == sym_b);
    res.ge    = (up >= left);
    if (res.match) begin
      res.score = up_left + 1'b1;
    end else if (res.ge) begin
      res.score = up;
    end else begin
      res.score = left;
    end
  end

endmodule

// ----- rtl/lcs_length_and_traceback_top.sv -----
// ----------------------------------------------------------------------------
// lcs_length_and_traceback_top - longest common subsequence engine
// Loads two byte strings, fills the score table, traces back, emits marks.
// ----------------------------------------------------------------------------
// Usage:
//  Input: a command transfers when start is high and busy is low. Opcode
//  append-first / append-second stores the symbol (busy stays
//  low); symbols beyond MAX_LEN are dropped and set the overflow flag.
//  Opcode run raises busy, fills the score table, traces back and emits
//  max(first, second) results (at least one). Opcode 3 is ignored.
//  Output: each result is on out_data for one cycle with out_strobe high;
//  the receiver cannot stall, so results stream one per cycle.
//  A run fills the score table one cell a cycle (set by the single score
//  table read port), then traces back with a read state and a decide state
//  per step, then emits the results. Busy drops with the last result.
//  Reset (synchronous, rst_n low) empties both strings and clears overflow;
//  row and column zero of the table are never stored but read as zero, so
//  the table memory needs no clearing pass.
// ----------------------------------------------------------------------------
module lcs_length_and_traceback_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  lcs_pkg::in_t  in_data,
  output logic          out_strobe,
  output lcs_pkg::out_t out_data
);

  localparam int CW  = lcs_pkg::CW;
  localparam int IW  = lcs_pkg::IW;
  localparam int SW  = lcs_pkg::SW;
  localparam int TAW = lcs_pkg::TAW;
  localparam int ML  = lcs_pkg::MAX_LEN;

  // memories
  logic [7:0]    first_mem  [ML];
  logic [7:0]    second_mem [ML];
  logic [SW-1:0] tbl_mem    [ML*ML + 2*ML + 1];

  lcs_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] first_cnt_r, first_cnt_nxt;
  logic [CW-1:0] second_cnt_r, second_cnt_nxt;
  logic          ovf_r, ovf_nxt;

  // issue position (also the traceback position)
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic          iss_done_r, iss_done_nxt;
  // compute stage of the fill pipeline
  logic          s2_vld_r, s2_vld_nxt;
  logic [CW-1:0] i2_r, i2_nxt, j2_r, j2_nxt;
  logic [SW-1:0] up_prev_r, up_prev_nxt;
  logic [SW-1:0] left_r, left_nxt;
  logic [SW-1:0] len_r, len_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [ML-1:0] fmarks_r, fmarks_nxt, smarks_r, smarks_nxt;
  logic [CW-1:0] k_r, k_nxt;

  // memory read data and read-during-write bypass
  logic [7:0]    first_q_r, second_q_r;
  logic [SW-1:0] tbl_q_r, byp_d_r;
  logic          byp_r;

  logic          accept;
  logic          app_first_we, app_second_we;
  logic          tbl_we;
  logic [TAW-1:0] tbl_wa, tbl_ra;
  logic [IW-1:0] ra_first, ra_second;
  logic [SW-1:0] tbl_rd;

  logic [7:0]    cu_a, cu_b;
  logic [SW-1:0] cu_up, cu_ul, cu_left;
  lcs_pkg::cell_res_t cu_res;

  logic [CW-1:0] emit_cnt;
  logic          emit_last;
  logic          fill_last;
  lcs_pkg::out_t out_nxt;
  logic          strobe_r;
  lcs_pkg::out_t out_r;

  assign accept   = start && !busy;
  assign busy     = (state_r != lcs_pkg::ST_IDLE);
  assign out_strobe = strobe_r;
  assign out_data   = out_r;

  // read addresses are shared by fill issue and traceback
  assign ra_first  = IW'(i_r - 1'b1);
  assign ra_second = IW'(j_r - 1'b1);
  assign tbl_ra    = lcs_pkg::tbl_addr(CW'(i_r - 1'b1), j_r);
  assign tbl_wa    = lcs_pkg::tbl_addr(i2_r, j2_r);
  assign tbl_rd    = byp_r ? byp_d_r : tbl_q_r;

  assign app_first_we  = accept && (in_data.opcode == lcs_pkg::OP_APPEND_FIRST)
                         && (first_cnt_r < CW'(ML));
  assign app_second_we = accept && (in_data.opcode == lcs_pkg::OP_APPEND_SECOND)
                         && (second_cnt_r < CW'(ML));

  assign tbl_we    = (state_r == lcs_pkg::ST_FILL) && s2_vld_r;
  assign fill_last = tbl_we && (i2_r == first_cnt_r) && (j2_r == second_cnt_r);

  assign emit_cnt  = (first_cnt_r == '0 && second_cnt_r == '0) ? CW'(1) :
                     (first_cnt_r > second_cnt_r) ? first_cnt_r : second_cnt_r;
  assign emit_last = (k_r + 1'b1 == emit_cnt);

  // shared unit operands: fill cell in FILL, traceback decision otherwise
  always_comb begin
    cu_a = first_q_r;
    cu_b = second_q_r;
    if (state_r == lcs_pkg::ST_FILL) begin
      cu_up   = (i2_r == CW'(1)) ? '0 : tbl_rd;
      cu_ul   = (j2_r == CW'(1)) ? '0 : up_prev_r;
      cu_left = (j2_r == CW'(1)) ? '0 : left_r;
    end else begin
      cu_up   = (i_r == CW'(1)) ? '0 : tbl_rd;
      cu_ul   = '0;
      cu_left = cur_r;   // up equals cur exactly when up >= cur
    end
  end

  lcs_cell_unit u_cell (
    .sym_a   (cu_a),
    .sym_b   (cu_b),
    .up      (cu_up),
    .up_left (cu_ul),
    .left    (cu_left),
    .res     (cu_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lcs_pkg::ST_IDLE: begin
        if (accept && in_data.opcode == lcs_pkg::OP_RUN) begin
          if (first_cnt_r == '0 || second_cnt_r == '0) begin
            state_nxt = lcs_pkg::ST_EMIT;
          end else begin
            state_nxt = lcs_pkg::ST_FILL;
          end
        end
      end
      lcs_pkg::ST_FILL: begin
        if (fill_last) state_nxt = lcs_pkg::ST_TB_RD;
      end
      lcs_pkg::ST_TB_RD: begin
        if (i_r == '0 || j_r == '0) begin
          state_nxt = lcs_pkg::ST_EMIT;
        end else begin
          state_nxt = lcs_pkg::ST_TB_DEC;
        end
      end
      lcs_pkg::ST_TB_DEC: state_nxt = lcs_pkg::ST_TB_RD;
      lcs_pkg::ST_EMIT: begin
        if (emit_last) state_nxt = lcs_pkg::ST_IDLE;
      end
      default: state_nxt = lcs_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    ovf_nxt        = ovf_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    iss_done_nxt   = iss_done_r;
    s2_vld_nxt     = 1'b0;
    i2_nxt         = i_r;
    j2_nxt         = j_r;
    up_prev_nxt    = up_prev_r;
    left_nxt       = left_r;
    len_nxt        = len_r;
    cur_nxt        = cur_r;
    fmarks_nxt     = fmarks_r;
    smarks_nxt     = smarks_r;
    k_nxt          = k_r;
    out_nxt        = out_r;

    case (state_r)
      lcs_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data.opcode)
            lcs_pkg::OP_APPEND_FIRST: begin
              if (app_first_we) first_cnt_nxt = first_cnt_r + 1'b1;
              else              ovf_nxt = 1'b1;
            end
            lcs_pkg::OP_APPEND_SECOND: begin
              if (app_second_we) second_cnt_nxt = second_cnt_r + 1'b1;
              else               ovf_nxt = 1'b1;
            end
            lcs_pkg::OP_RUN: begin
              i_nxt        = CW'(1);
              j_nxt        = CW'(1);
              iss_done_nxt = 1'b0;
              len_nxt      = '0;
              fmarks_nxt   = '0;
              smarks_nxt   = '0;
              k_nxt        = '0;
            end
            default: ;
          endcase
        end
      end
      lcs_pkg::ST_FILL: begin
        if (!iss_done_r) begin
          s2_vld_nxt = 1'b1;
          if (j_r == second_cnt_r) begin
            j_nxt = CW'(1);
            if (i_r == first_cnt_r) iss_done_nxt = 1'b1;
            else                    i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
        if (tbl_we) begin
          left_nxt    = cu_res.score;
          up_prev_nxt = cu_up;
        end
        if (fill_last) begin
          s2_vld_nxt = 1'b0;
          len_nxt    = cu_res.score;
          cur_nxt    = cu_res.score;
          i_nxt      = first_cnt_r;
          j_nxt      = second_cnt_r;
        end
      end
      lcs_pkg::ST_TB_RD: ;
      lcs_pkg::ST_TB_DEC: begin
        if (cu_res.match) begin
          fmarks_nxt[ra_first]  = 1'b1;
          smarks_nxt[ra_second] = 1'b1;
          i_nxt   = i_r - 1'b1;
          j_nxt   = j_r - 1'b1;
          cur_nxt = cur_r - 1'b1;
        end else if (cu_res.ge) begin
          i_nxt = i_r - 1'b1;
        end else begin
          j_nxt = j_r - 1'b1;
        end
      end
      lcs_pkg::ST_EMIT: begin
        out_nxt.position   = lcs_pkg::POS_W'(k_r);
        out_nxt.in_first   = (k_r < first_cnt_r) && fmarks_r[k_r[IW-1:0]];
        out_nxt.in_second  = (k_r < second_cnt_r) && smarks_r[k_r[IW-1:0]];
        out_nxt.lcs_length = 6'(len_r);
        out_nxt.overflow   = ovf_r;
        out_nxt.last       = emit_last;
        k_nxt              = k_r + 1'b1;
        if (emit_last) begin
          first_cnt_nxt  = '0;
          second_cnt_nxt = '0;
          ovf_nxt        = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lcs_pkg::ST_IDLE;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      ovf_r        <= 1'b0;
      s2_vld_r     <= 1'b0;
      iss_done_r   <= 1'b1;
      strobe_r     <= 1'b0;
      byp_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      ovf_r        <= ovf_nxt;
      s2_vld_r     <= s2_vld_nxt;
      iss_done_r   <= iss_done_nxt;
      strobe_r     <= (state_r == lcs_pkg::ST_EMIT);
      byp_r        <= tbl_we && (tbl_wa == tbl_ra);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    i2_r      <= i2_nxt;
    j2_r      <= j2_nxt;
    up_prev_r <= up_prev_nxt;
    left_r    <= left_nxt;
    len_r     <= len_nxt;
    cur_r     <= cur_nxt;
    fmarks_r  <= fmarks_nxt;
    smarks_r  <= smarks_nxt;
    k_r       <= k_nxt;
    out_r     <= out_nxt;
    byp_d_r   <= cu_res.score;
  end

  // string buffers
  always_ff @(posedge clk) begin
    if (app_first_we) first_mem[first_cnt_r[IW-1:0]] <= in_data.symbol;
    first_q_r <= first_mem[ra_first];
  end

  always_ff @(posedge clk) begin
    if (app_second_we) second_mem[second_cnt_r[IW-1:0]] <= in_data.symbol;
    second_q_r <= second_mem[ra_second];
  end

  // score table
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= cu_res.score;
    tbl_q_r <= tbl_mem[tbl_ra];
  end

  // checks
  a_run_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.opcode == lcs_pkg::OP_RUN |=> busy)
    else $error("run transfer did not start the sequencer");

  a_busy_during_results: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.last |-> busy)
    else $error("busy dropped before the final result");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_data.lcs_length <= 6'(ML))
    else $error("LCS length beyond capacity");

  a_mark_needs_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_data.in_first || out_data.in_second)
      |-> out_data.lcs_length != '0)
    else $error("position marked with zero LCS length");

endmodule

// ----- dv/lcs_length_and_traceback_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcs_length_and_traceback_top_tb - self-checking bench for the LCS engine
// Sends string appends and run commands, predicts the per-position marks,
// subsequence length, overflow and last flags, and checks every result strobe
// against the oldest prediction.
// ----------------------------------------------------------------------------
module lcs_length_and_traceback_top_tb;

  // the one opcode the engine must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // cycles with no transfer on either side before the run is declared hung;
  // it lies well above the silent stretch of a 32x32 run, so it leaves wide margin
  localparam int WATCHDOG_LIMIT = 20000;
  // tail after the last expected result, in case a stray strobe follows
  localparam int DRAIN_CYCLES   = 50;

  logic           clk        = 1'b0;
  logic           rst_n      = 1'b0;
  logic           start      = 1'b0;
  lcs_pkg::in_t   in_data    = '0;
  logic           busy;
  logic           out_strobe;
  lcs_pkg::out_t  out_data;

  // predictor copy of the engine state
  logic [7:0] first_syms  [lcs_pkg::MAX_LEN];
  logic [7:0] second_syms [lcs_pkg::MAX_LEN];
  int         first_len    = 0;
  int         second_len   = 0;
  logic       dropped_flag = 1'b0;

  lcs_pkg::out_t expected_marks_q [$];
  int         mismatch_count = 0;
  int         commands_sent  = 0;   // counts commands the engine acts on
  bit         idle_enable    = 1'b1;
  int         quiet_cycles   = 0;
  logic [7:0] alphabet [4];         // narrow symbol set, so strings share symbols

  lcs_length_and_traceback_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Fill the score table, trace back from the bottom-right corner and queue
  // one expected result per position. Tie rule on the trace: diagonal on a
  // symbol match, else up when the upper cell holds the same score, else left.
  function automatic void lcs_commit_run();
    logic [lcs_pkg::SW-1:0]      score [lcs_pkg::ROW][lcs_pkg::ROW];
    logic [lcs_pkg::MAX_LEN-1:0] first_hit;
    logic [lcs_pkg::MAX_LEN-1:0] second_hit;
    int                 i;
    int                 j;
    int                 k;
    int                 total;
    lcs_pkg::out_t      res;
    for (i = 0; i < lcs_pkg::ROW; i++) begin
      score[i][0] = '0;
      score[0][i] = '0;
    end
    for (i = 1; i <= first_len; i++) begin
      for (j = 1; j <= second_len; j++) begin
        if (first_syms[i-1] == second_syms[j-1]) begin
          score[i][j] = score[i-1][j-1] + 1'b1;
        end else begin
          score[i][j] = (score[i-1][j] > score[i][j-1]) ? score[i-1][j] : score[i][j-1];
        end
      end
    end
    first_hit  = '0;
    second_hit = '0;
    i = first_len;
    j = second_len;
    while (i > 0 && j > 0) begin
      if (first_syms[i-1] == second_syms[j-1]) begin
        first_hit[i-1]  = 1'b1;
        second_hit[j-1] = 1'b1;
        i--;
        j--;
      end else if (score[i][j] == score[i-1][j]) begin
        i--;
      end else begin
        j--;
      end
    end
    // both strings empty still yields one result
    total = (first_len > second_len) ? first_len : second_len;
    if (total == 0) total = 1;
    for (k = 0; k < total; k++) begin
      res.position   = lcs_pkg::POS_W'(k);
      res.in_first   = (k < first_len)  ? first_hit[k]  : 1'b0;
      res.in_second  = (k < second_len) ? second_hit[k] : 1'b0;
      res.lcs_length = 6'(score[first_len][second_len]);
      res.overflow   = dropped_flag;
      res.last       = (k == total - 1);
      expected_marks_q.push_back(res);
    end
    first_len    = 0;
    second_len   = 0;
    dropped_flag = 1'b0;
  endfunction

  function automatic void apply_command(input lcs_pkg::in_t cmd);
    case (cmd.opcode)
      lcs_pkg::OP_APPEND_FIRST: begin
        if (first_len < lcs_pkg::MAX_LEN) first_syms[first_len++] = cmd.symbol;
        else dropped_flag = 1'b1;
      end
      lcs_pkg::OP_APPEND_SECOND: begin
        if (second_len < lcs_pkg::MAX_LEN) second_syms[second_len++] = cmd.symbol;
        else dropped_flag = 1'b1;
      end
      lcs_pkg::OP_RUN: lcs_commit_run();
      default: ;  // unused opcode: no effect
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_result(input lcs_pkg::out_t got);
    lcs_pkg::out_t want;
    if (expected_marks_q.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %h", $time, got);
      mismatch_count++;
      return;
    end
    want = expected_marks_q.pop_front();
    check_field("position",   8'(want.position),   8'(got.position));
    check_field("in_first",   8'(want.in_first),   8'(got.in_first));
    check_field("in_second",  8'(want.in_second),  8'(got.in_second));
    check_field("lcs_length", 8'(want.lcs_length), 8'(got.lcs_length));
    check_field("overflow",   8'(want.overflow),   8'(got.overflow));
    check_field("last",       8'(want.last),       8'(got.last));
  endfunction

  // Sampled at the edge, before any NBA of this step lands: a result is
  // checked first, then a command transferred at the same edge is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) check_result(out_data);
      if (start && !busy) apply_command(in_data);
    end
  end

  // Watchdog: cycles with no transfer in either direction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // One command transfer; optional random idle cycles ahead of it.
  // start stays high between back-to-back commands.
  task automatic send_command(input logic [1:0] op, input logic [7:0] sym);
    if (idle_enable) begin
      while ($urandom_range(99) < 32) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    in_data <= lcs_pkg::in_t'{op, sym};
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op != OP_UNUSED) commands_sent++;
  endtask

  function automatic logic [7:0] pick_symbol(input bit narrow);
    return narrow ? alphabet[$urandom_range(3)] : 8'($urandom);
  endfunction

  // mostly short strings, a few up to and past capacity
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(8);
    if (r < 95) return $urandom_range(31, 9);
    return $urandom_range(lcs_pkg::MAX_LEN + 3, lcs_pkg::MAX_LEN);
  endfunction

  // Interleaved appends of two strings, then a run.
  task automatic send_pair(input int n_first, input int n_second, input bit narrow);
    int a;
    int b;
    int n;
    a = 0;
    b = 0;
    for (n = 0; n < 4; n++) alphabet[n] = 8'($urandom);
    while (a < n_first || b < n_second) begin
      if (b >= n_second || (a < n_first && $urandom_range(1))) begin
        send_command(lcs_pkg::OP_APPEND_FIRST, pick_symbol(narrow));
        a++;
      end else begin
        send_command(lcs_pkg::OP_APPEND_SECOND, pick_symbol(narrow));
        b++;
      end
    end
    send_command(lcs_pkg::OP_RUN, 8'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // run with nothing loaded: single result, everything zero, last set
  task automatic test_empty_run();
    send_command(lcs_pkg::OP_RUN, 8'hFF);
  endtask

  // symbol byte extremes; strings of unequal length
  task automatic test_symbol_extremes();
    send_command(lcs_pkg::OP_APPEND_FIRST,  8'h00);
    send_command(lcs_pkg::OP_APPEND_FIRST,  8'hFF);
    send_command(lcs_pkg::OP_APPEND_SECOND, 8'hFF);
    send_command(lcs_pkg::OP_RUN,           8'h00);
  endtask

  // opcode 3 must not touch either string
  task automatic test_ignored_opcode();
    send_command(OP_UNUSED,                 8'hAA);
    send_command(lcs_pkg::OP_APPEND_FIRST,  8'h55);
    send_command(OP_UNUSED,                 8'h55);
    send_command(lcs_pkg::OP_APPEND_SECOND, 8'h55);
    send_command(lcs_pkg::OP_RUN,           8'hAA);
  endtask

  // only one string loaded, first then second
  task automatic test_one_sided();
    send_command(lcs_pkg::OP_APPEND_FIRST,  8'h12);
    send_command(lcs_pkg::OP_APPEND_FIRST,  8'h34);
    send_command(lcs_pkg::OP_RUN,           8'h00);
    send_command(lcs_pkg::OP_APPEND_SECOND, 8'h56);
    send_command(lcs_pkg::OP_APPEND_SECOND, 8'h78);
    send_command(lcs_pkg::OP_APPEND_SECOND, 8'h9A);
    send_command(lcs_pkg::OP_RUN,           8'h00);
  endtask

  // "AB" vs "BA": equal scores up and left, traceback must prefer up
  task automatic test_tie_break();
    send_command(lcs_pkg::OP_APPEND_FIRST,  8'h41);
    send_command(lcs_pkg::OP_APPEND_FIRST,  8'h42);
    send_command(lcs_pkg::OP_APPEND_SECOND, 8'h42);
    send_command(lcs_pkg::OP_APPEND_SECOND, 8'h41);
    send_command(lcs_pkg::OP_RUN,           8'h00);
  endtask

  // both strings pushed past capacity: longest run, overflow on both sides
  task automatic test_full_capacity();
    send_pair(lcs_pkg::MAX_LEN + 1, lcs_pkg::MAX_LEN + 1, 1'b1);
  endtask

  // random string pairs plus the odd ignored command
  task automatic test_random_runs(input int budget);
    while (commands_sent < budget) begin
      if ($urandom_range(99) < 5) begin
        send_command(OP_UNUSED, 8'($urandom));
      end else begin
        send_pair(pick_length(), pick_length(), $urandom_range(99) < 75);
      end
    end
  endtask

  // sender holds off until every queued result has been seen
  task automatic test_drain_pause();
    start <= 1'b0;
    @(posedge clk);
    while (expected_marks_q.size() != 0) @(posedge clk);
  endtask

  // long stretch with start held high whenever possible
  task automatic test_back_to_back();
    int n;
    idle_enable = 1'b0;
    for (n = 0; n < 6; n++) send_pair($urandom_range(8), $urandom_range(8), 1'b1);
    idle_enable = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_run();
    test_symbol_extremes();
    test_ignored_opcode();
    test_one_sided();
    test_tie_break();
    test_full_capacity();
    test_random_runs(180);
    test_drain_pause();
    test_back_to_back();
    test_random_runs(320);

    // everything sent; let the last run finish streaming
    start <= 1'b0;
    @(posedge clk);
    while (expected_marks_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_marks_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
